>>> sv/cnlc_pkg.sv
// ----------------------------------------------------------------------------
// cnlc_pkg: shared types and helpers for the card number Luhn classifier
// Brand codes, the result record and the small Luhn digit functions.
// ----------------------------------------------------------------------------
`default_nettype none

package cnlc_pkg;

    localparam int DIGIT_W  = 4;
    localparam int LENGTH_W = 5;
    localparam int RES_W    = 4;   // residue of a Luhn sum modulo ten

    // largest decimal digit and the Luhn modulus
    localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
    localparam logic [RES_W-1:0]   LUHN_MOD   = 4'd10;

    // brand lengths and prefix digits
    localparam logic [LENGTH_W-1:0] LEN_AMEX   = 5'd15;
    localparam logic [LENGTH_W-1:0] LEN_MC     = 5'd16;
    localparam logic [LENGTH_W-1:0] LEN_VISA_S = 5'd13;
    localparam logic [DIGIT_W-1:0]  AMEX_D0    = 4'd3;
    localparam logic [DIGIT_W-1:0]  AMEX_D1_A  = 4'd4;
    localparam logic [DIGIT_W-1:0]  AMEX_D1_B  = 4'd7;
    localparam logic [DIGIT_W-1:0]  MC_D0      = 4'd5;
    localparam logic [DIGIT_W-1:0]  MC_D1_LO   = 4'd1;
    localparam logic [DIGIT_W-1:0]  MC_D1_HI   = 4'd5;
    localparam logic [DIGIT_W-1:0]  VISA_D0    = 4'd4;

    typedef enum logic [1:0] {
        BRAND_INVALID    = 2'd0,
        BRAND_AMEX       = 2'd1,
        BRAND_MASTERCARD = 2'd2,
        BRAND_VISA       = 2'd3
    } t_brand;

    typedef struct packed {
        t_brand              brand;
        logic                checksum_ok;
        logic [LENGTH_W-1:0] length_seen;
    } t_result;

    // digit doubled, with nine taken off when it passes nine
    function automatic logic [DIGIT_W-1:0] luhn_double(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W:0] t;
        t = {d, 1'b0};
        if (t > {1'b0, DIGIT_MAX}) begin
            luhn_double = DIGIT_W'(t - {1'b0, DIGIT_MAX});
        end else begin
            luhn_double = t[DIGIT_W-1:0];
        end
    endfunction

    // add a digit into a residue modulo ten
    function automatic logic [RES_W-1:0] add_mod10(input logic [RES_W-1:0] a,
                                                   input logic [DIGIT_W-1:0] b);
        logic [RES_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, LUHN_MOD}) begin
            add_mod10 = RES_W'(s - {1'b0, LUHN_MOD});
        end else begin
            add_mod10 = s[RES_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/cnlc_digit_if.sv
// ----------------------------------------------------------------------------
// cnlc_digit_if: digit request channel
// Valid/ready channel carrying one card number digit and its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface cnlc_digit_if import cnlc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit;
    logic               last_digit;

    modport source (output valid, output digit, output last_digit, input ready);
    modport sink   (input valid, input digit, input last_digit, output ready);
endinterface

`default_nettype wire

>>> sv/cnlc_result_if.sv
// ----------------------------------------------------------------------------
// cnlc_result_if: result request channel
// Valid/ready channel carrying brand, checksum verdict and length.
// ----------------------------------------------------------------------------
`default_nettype none

interface cnlc_result_if import cnlc_pkg::*;;
    logic                valid;
    logic                ready;
    logic [1:0]          brand;
    logic                checksum_ok;
    logic [LENGTH_W-1:0] length_seen;

    modport source (output valid, output brand, output checksum_ok,
                    output length_seen, input ready);
    modport sink   (input valid, input brand, input checksum_ok,
                    input length_seen, output ready);
endinterface

`default_nettype wire

>>> sv/cnlc_luhn_acc.sv
// ----------------------------------------------------------------------------
// cnlc_luhn_acc: running Luhn sums, digit count and prefix
// Keeps both parity sums as residues modulo ten and forms the result of a
// number from the state as updated by its final digit.
// ----------------------------------------------------------------------------
`default_nettype none

module cnlc_luhn_acc
    import cnlc_pkg::*;
#(
    parameter int MAX_DIGITS = 31
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [DIGIT_W-1:0]  i_digit,
    input  wire logic                i_last_digit,
    output t_result                  o_result
);

    localparam logic [LENGTH_W-1:0] COUNT_MAX = LENGTH_W'(MAX_DIGITS);

    logic [RES_W-1:0]    r_res_even, n_res_even;
    logic [RES_W-1:0]    r_res_odd,  n_res_odd;
    logic [LENGTH_W-1:0] r_count,    n_count;
    logic [DIGIT_W-1:0]  r_first,    n_first;
    logic [DIGIT_W-1:0]  r_second,   n_second;

    logic [DIGIT_W-1:0]  d_sat;
    logic [DIGIT_W-1:0]  d_dbl;
    logic [RES_W-1:0]    sel_res;
    logic                ok;
    t_brand              brand;

    // saturate the digit and double it
    assign d_sat = (i_digit > DIGIT_MAX) ? DIGIT_MAX : i_digit;
    assign d_dbl = luhn_double(d_sat);

    // state after this digit, counting stops at the limit
    always_comb begin
        n_res_even = r_res_even;
        n_res_odd  = r_res_odd;
        n_count    = r_count;
        n_first    = r_first;
        n_second   = r_second;
        if (r_count < COUNT_MAX) begin
            if (!r_count[0]) begin
                n_res_even = add_mod10(r_res_even, d_dbl);
                n_res_odd  = add_mod10(r_res_odd, d_sat);
            end else begin
                n_res_odd  = add_mod10(r_res_odd, d_dbl);
                n_res_even = add_mod10(r_res_even, d_sat);
            end
            if (r_count == '0) begin
                n_first = d_sat;
            end
            if (r_count == LENGTH_W'(1)) begin
                n_second = d_sat;
            end
            n_count = r_count + LENGTH_W'(1);
        end
    end

    // checksum from the sum that fits the length parity
    assign sel_res = n_count[0] ? n_res_odd : n_res_even;
    assign ok      = (sel_res == '0);

    // brand from length and leading digits, invalid when the checksum fails
    always_comb begin
        brand = BRAND_INVALID;
        if (n_count == LEN_AMEX && n_first == AMEX_D0 &&
            (n_second == AMEX_D1_A || n_second == AMEX_D1_B)) begin
            brand = BRAND_AMEX;
        end else if (n_count == LEN_MC && n_first == MC_D0 &&
                     n_second >= MC_D1_LO && n_second <= MC_D1_HI) begin
            brand = BRAND_MASTERCARD;
        end else if ((n_count == LEN_VISA_S || n_count == LEN_MC) &&
                     n_first == VISA_D0) begin
            brand = BRAND_VISA;
        end
        if (!ok) begin
            brand = BRAND_INVALID;
        end
    end

    assign o_result.brand       = brand;
    assign o_result.checksum_ok = ok;
    assign o_result.length_seen = n_count;

    // state update, cleared once a number ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_digit)) begin
            r_res_even <= '0;
            r_res_odd  <= '0;
            r_count    <= '0;
            r_first    <= '0;
            r_second   <= '0;
        end else if (i_accept) begin
            r_res_even <= n_res_even;
            r_res_odd  <= n_res_odd;
            r_count    <= n_count;
            r_first    <= n_first;
            r_second   <= n_second;
        end
    end

endmodule

`default_nettype wire

>>> sv/card_number_luhn_classifier.sv
// ----------------------------------------------------------------------------
// card_number_luhn_classifier: Luhn check and card brand from a digit stream
// Takes card number digits most significant first and gives one result per
// number: brand, checksum verdict and digit count.
// ----------------------------------------------------------------------------
//   channel    dir  payload                              handshake
//   i_digit    in   digit[3:0], last_digit               valid / ready
//   o_result   out  brand[1:0], checksum_ok, length[4:0] valid / ready
//
// one digit is taken per cycle; the result of a number is presented the
// cycle after its final digit is accepted, from a single output register
// a digit is refused only while that output register holds a result that
// the sink does not take in the same cycle
// reset is synchronous and active low; it empties the output register and
// clears the running sums
// ----------------------------------------------------------------------------
`default_nettype none

module card_number_luhn_classifier
    import cnlc_pkg::*;
#(
    parameter int MAX_DIGITS = 31
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    cnlc_digit_if.sink     i_digit,
    cnlc_result_if.source  o_result
);

    logic    in_accept;
    t_result acc_result;
    logic    r_out_valid;
    t_result r_out;

    // take a digit whenever the output register is free or being drained
    assign i_digit.ready = !r_out_valid || o_result.ready;
    assign in_accept     = i_digit.valid && i_digit.ready;

    cnlc_luhn_acc #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_digit      (i_digit.digit),
        .i_last_digit (i_digit.last_digit),
        .o_result     (acc_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && i_digit.last_digit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_digit.last_digit) begin
            r_out <= acc_result;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.brand       = r_out.brand;
    assign o_result.checksum_ok = r_out.checksum_ok;
    assign o_result.length_seen = r_out.length_seen;

    // a final digit always leaves a result in the output register
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_digit.last_digit |=> r_out_valid)
        else $error("final digit produced no result");

    // a digit that is not final never creates a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !i_digit.last_digit && o_result.ready |=> !r_out_valid)
        else $error("result appeared without a final digit");

    // any brand implies a passing checksum
    a_brand_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.brand != BRAND_INVALID |-> r_out.checksum_ok)
        else $error("brand given with failing checksum");

    // amex only at its length
    a_amex_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.brand == BRAND_AMEX |-> r_out.length_seen == LEN_AMEX)
        else $error("amex brand at wrong length");

endmodule

`default_nettype wire

>>> test/card_number_luhn_classifier_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// card_number_luhn_classifier_test: self-checking bench for the Luhn classifier
// Streams card numbers one digit per request: a short table of hand-picked
// numbers, then random numbers that are mostly well formed (brand prefixes and
// lengths, fixed-up check digits) with noise, short and overlong numbers mixed
// in. Each result is compared with its table entry or a local model of the digit sums.
// ----------------------------------------------------------------------------

module card_number_luhn_classifier_test
    import cnlc_pkg::*;
;

    localparam int MAX_DIGITS    = 31;
    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_DIGITS = 1800;
    localparam int STALL_LIMIT   = 1000;
    localparam int TAIL_CYCLES   = 8;
    localparam int REPORT_MAX    = 10;

    // brand prefixes as two-digit values
    localparam int AMEX_PFX_A = 34;
    localparam int AMEX_PFX_B = 37;
    localparam int MC_PFX_LO  = 51;
    localparam int MC_PFX_HI  = 55;
    localparam int VISA_LEAD  = 4;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_BURSTY
    } t_stall_style;

    typedef enum int {
        CARD_AMEX,
        CARD_MC,
        CARD_VISA,
        CARD_NEAR_MISS,
        CARD_NOISE,
        CARD_LONG,
        CARD_SHORT
    } t_card_kind;

    typedef struct {
        string   digits;    // hex characters, a..f give digits above nine
        bit      typed;
        t_result want;
    } t_card_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cnlc_digit_if  digit_ch ();
    cnlc_result_if result_ch ();

    card_number_luhn_classifier #(
        .MAX_DIGITS (MAX_DIGITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_digit  (digit_ch),
        .o_result (result_ch)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    t_result      pending_verdicts [$];
    int           errors       = 0;
    int           results_seen = 0;
    int           idle_cycles  = 0;
    int           burst_left   = 0;
    int           digits_sent  = 0;
    logic [31:0]  rx_cycle     = '0;
    t_stall_style rx_style     = RX_ALWAYS;
    t_card_row    directed_cards [5];

    // local copy of the running sums
    logic [8:0] sum_dbl_odd  = '0;
    logic [8:0] sum_dbl_even = '0;
    logic [4:0] digit_count  = '0;
    logic [6:0] leading_pair = '0;

    // digit clipped to nine, optionally doubled with nine taken off
    function automatic logic [3:0] digit_weight(input logic [3:0] d, input bit doubled);
        logic [4:0] t;
        t = (d > 4'd9) ? 5'd9 : {1'b0, d};
        if (doubled) begin
            t = t << 1;
            if (t > 5'd9) begin
                t = t - 5'd9;
            end
        end
        return t[3:0];
    endfunction

    // advance the sums by one digit; on the last digit give the verdict
    function automatic void luhn_classify_digit(input logic [3:0] d_in, input bit is_last,
                                                output bit has_result,
                                                output t_result verdict);
        logic [3:0] d;
        logic [8:0] sum;
        logic [4:0] len;
        bit         ok;
        t_brand     brand;
        d = (d_in > 4'd9) ? 4'd9 : d_in;
        has_result = 1'b0;
        verdict = '0;
        if (digit_count < MAX_DIGITS) begin
            if (!digit_count[0]) begin
                sum_dbl_even = sum_dbl_even + 9'(digit_weight(d, 1'b1));
                sum_dbl_odd  = sum_dbl_odd + 9'(digit_weight(d, 1'b0));
            end else begin
                sum_dbl_odd  = sum_dbl_odd + 9'(digit_weight(d, 1'b1));
                sum_dbl_even = sum_dbl_even + 9'(digit_weight(d, 1'b0));
            end
            if (digit_count == 0) begin
                leading_pair = 7'(d);
            end else if (digit_count == 1) begin
                leading_pair = 7'(leading_pair * 10 + d);
            end
            digit_count = digit_count + 5'd1;
        end
        if (!is_last) begin
            return;
        end
        len = digit_count;
        sum = len[0] ? sum_dbl_odd : sum_dbl_even;
        ok = (sum % 10) == 0;
        brand = BRAND_INVALID;
        if (len == LEN_AMEX && (leading_pair == AMEX_PFX_A || leading_pair == AMEX_PFX_B)) begin
            brand = BRAND_AMEX;
        end else if (len == LEN_MC && leading_pair >= MC_PFX_LO && leading_pair <= MC_PFX_HI) begin
            brand = BRAND_MASTERCARD;
        end else if ((len == LEN_VISA_S || len == LEN_MC) && leading_pair / 10 == VISA_LEAD) begin
            brand = BRAND_VISA;
        end
        if (!ok) begin
            brand = BRAND_INVALID;
        end
        has_result = 1'b1;
        verdict.brand = brand;
        verdict.checksum_ok = ok;
        verdict.length_seen = len;
        sum_dbl_odd  = '0;
        sum_dbl_even = '0;
        digit_count  = '0;
        leading_pair = '0;
    endfunction

    // one digit request, with bursts and gaps on the sending side
    task automatic send_digit(input logic [3:0] d, input bit is_last, input bit typed,
                              input t_result want);
        bit      has_result;
        t_result verdict;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                digit_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        digit_ch.valid      <= 1'b1;
        digit_ch.digit      <= d;
        digit_ch.last_digit <= is_last;
        do @(posedge i_clk); while (!digit_ch.ready);
        luhn_classify_digit(d, is_last, has_result, verdict);
        if (has_result) begin
            pending_verdicts.push_back(typed ? want : verdict);
        end
        digits_sent++;
    endtask

    // random card number, mostly shaped like a real brand
    task automatic send_random_card();
        logic [3:0] card [64];
        t_card_kind kind;
        int         len;
        int         s;
        kind = t_card_kind'($urandom_range(0, 6));
        for (int i = 0; i < 64; i++) begin
            if (kind == CARD_NOISE || $urandom_range(0, 19) == 0) begin
                card[i] = 4'($urandom_range(0, 15));
            end else begin
                card[i] = 4'($urandom_range(0, 9));
            end
        end
        case (kind)
            CARD_AMEX: begin
                len = 15;
                card[0] = 4'd3;
                card[1] = $urandom_range(0, 1) ? 4'd4 : 4'd7;
            end
            CARD_MC: begin
                len = 16;
                card[0] = 4'd5;
                card[1] = 4'($urandom_range(1, 5));
            end
            CARD_VISA: begin
                len = $urandom_range(0, 1) ? 13 : 16;
                card[0] = 4'd4;
            end
            CARD_NEAR_MISS: begin
                len = $urandom_range(12, 17);
                card[0] = 4'($urandom_range(3, 5));
            end
            CARD_NOISE: begin
                len = $urandom_range(1, 30);
            end
            CARD_LONG: begin
                len = ($urandom_range(0, 2) == 0) ? $urandom_range(32, 40)
                                                   : $urandom_range(17, 31);
            end
            default: begin
                len = $urandom_range(1, 4);
            end
        endcase
        // force a passing check digit most of the time
        if ($urandom_range(0, 3) != 0 && len <= MAX_DIGITS) begin
            s = 0;
            for (int i = 0; i < len - 1; i++) begin
                s += digit_weight(card[i], ((len - 1 - i) % 2) == 1);
            end
            card[len-1] = 4'((10 - s % 10) % 10);
        end
        for (int i = 0; i < len; i++) begin
            send_digit(card[i], i == len - 1, 1'b0, '0);
        end
    endtask

    // receiver stall pattern, style changes when the low byte of the cycle count is zero
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle[7:0] == 8'd0) begin
            rx_style <= t_stall_style'($urandom_range(0, 3));
        end
        case (rx_style)
            RX_ALWAYS: result_ch.ready <= 1'b1;
            RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: result_ch.ready <= (rx_cycle[1:0] == 2'd0);
            default:   result_ch.ready <= (rx_cycle[4:0] > 5'd24);
        endcase
    end

    // result check against the oldest pending verdict
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && ((digit_ch.valid && digit_ch.ready) ||
                        (result_ch.valid && result_ch.ready))) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX) begin
                    $display("result %0d: nothing expected, got brand %0d ok %0b length %0d",
                             results_seen, result_ch.brand, result_ch.checksum_ok,
                             result_ch.length_seen);
                end
            end else begin
                want = pending_verdicts.pop_front();
                if (result_ch.brand !== want.brand ||
                    result_ch.checksum_ok !== want.checksum_ok ||
                    result_ch.length_seen !== want.length_seen) begin
                    errors++;
                    if (errors <= REPORT_MAX) begin
                        $write("result %0d: brand exp %0d got %0d, ",
                               results_seen, want.brand, result_ch.brand);
                        $display("ok exp %0b got %0b, length exp %0d got %0d",
                                 want.checksum_ok, result_ch.checksum_ok,
                                 want.length_seen, result_ch.length_seen);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no request moving
    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // main stimulus
    initial begin
        i_rst_n             = 1'b0;
        digit_ch.valid      = 1'b0;
        digit_ch.digit      = '0;
        digit_ch.last_digit = 1'b0;
        result_ch.ready     = 1'b0;

        // zero alone, digit above nine alone, short prefix, clipped digits,
        // and a number longer than the counter can hold
        directed_cards[0] = '{"0", 1'b1, '{BRAND_INVALID, 1'b1, 5'd1}};
        directed_cards[1] = '{"f", 1'b1, '{BRAND_INVALID, 1'b0, 5'd1}};
        directed_cards[2] = '{"34", 1'b1, '{BRAND_INVALID, 1'b1, 5'd2}};
        directed_cards[3] = '{"b7", 1'b0, '0};
        directed_cards[4] = '{"00000000000000000000000000000000", 1'b1,
                              '{BRAND_INVALID, 1'b1, 5'd31}};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_cards[r]) begin
            for (int i = 0; i < directed_cards[r].digits.len(); i++) begin
                byte        c;
                logic [3:0] d;
                c = directed_cards[r].digits[i];
                d = (c >= "a") ? 4'(c - "a" + 10) : 4'(c - "0");
                send_digit(d, i == directed_cards[r].digits.len() - 1,
                           directed_cards[r].typed, directed_cards[r].want);
            end
        end

        while (digits_sent < RANDOM_DIGITS) begin
            send_random_card();
        end
        digit_ch.valid <= 1'b0;

        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0 && pending_verdicts.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
